@@ hdl/cbcc_pkg.sv @@
// Shared constants, operation codes and sequencer states of the sector cache
// tag and replacement controller. No dependencies.
package cbcc_pkg;

  localparam int LINES_DEF = 64;
  localparam int LINE_W    = 6;
  localparam int SECTOR_W  = 32;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SWEEP,
    S_VREAD,
    S_FILL,
    S_HIT,
    S_FSCAN,
    S_FEMIT,
    S_FEMPTY
  } state_e;

endpackage

@@ hdl/clock_buffer_cache_controller_core.sv @@
// Tag and clock-replacement controller of a fully associative sector cache.
// Access: accept, then a tag scan on one shared comparator that ends early on a hit,
// then a result on a hit, or on a miss a clock sweep when no line is free, a victim
// tag read and a fill. Flush: accept, then a scan of the lines with one writeback per
// dirty line, or one empty result when none is dirty. One item at a time; output
// stalls hold the sequencer. Async active-low reset clears valid, dirty, use, hand.
module clock_buffer_cache_controller_core #(
  parameter int LINES = cbcc_pkg::LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cbcc_pkg::OP_W-1:0]     operation_i,
  input  logic [cbcc_pkg::SECTOR_W-1:0] sector_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cbcc_pkg::LINE_W-1:0]   line_o,
  output logic                          hit_o,
  output logic                          fill_o,
  output logic                          writeback_o,
  output logic [cbcc_pkg::SECTOR_W-1:0] writeback_sector_o,
  output logic                          last_o
);

  localparam int IW = $clog2(LINES);       // line index width
  localparam int CW = $clog2(LINES + 1);   // scan counter, reaches LINES
  localparam int LW = cbcc_pkg::LINE_W;
  localparam int SW = cbcc_pkg::SECTOR_W;
  localparam int OW = cbcc_pkg::OP_W;

  cbcc_pkg::state_e state_q, state_d;

  // Beat captured at acceptance
  logic [OW-1:0]    op_q, op_d;
  logic [SW-1:0]    sector_q, sector_d;

  // Scan bookkeeping
  logic [CW-1:0]    idx_q, idx_d;
  logic             chk_q, chk_d;          // a tag read is due for compare
  logic [IW-1:0]    chk_idx_q, chk_idx_d;
  logic             free_found_q, free_found_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic [IW-1:0]    victim_q, victim_d;

  // Replacement state
  logic [IW-1:0]    hand_q, hand_d;
  logic [LINES-1:0] valid_q, valid_d;
  logic [LINES-1:0] dirty_q, dirty_d;
  logic [LINES-1:0] used_q, used_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  logic [LW-1:0]    line_q, line_d;
  logic             hit_q, hit_d;
  logic             fill_q, fill_d;
  logic             wb_q, wb_d;
  logic [SW-1:0]    wbsec_q, wbsec_d;
  logic             last_q, last_d;

  // Tag store port
  logic             tag_we;
  logic [IW-1:0]    tag_rd_addr;
  logic [SW-1:0]    tag_rdata;

  logic             in_acc;
  logic             out_free;
  logic             hit_now;
  logic             scan_end;
  logic [IW-1:0]    idx_line;
  logic [IW-1:0]    hand_nxt;
  logic [LINES-1:0] vd;
  logic [LINES-1:0] above;
  logic             more_dirty;
  logic             emit;

  cbcc_tag_ram #(
    .DEPTH (LINES),
    .AW    (IW),
    .DW    (SW)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (tag_we),
    .wr_addr_i (victim_q),
    .wr_data_i (sector_q),
    .rd_addr_i (tag_rd_addr),
    .rd_data_o (tag_rdata)
  );

  // Handshake: take a beat only when the sequencer is parked
  assign in_stall_o = (state_q != cbcc_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign idx_line = idx_q[IW-1:0];
  assign scan_end = (idx_q == CW'(LINES));

  // Shared comparator: tag read last cycle against the sector being looked up
  assign hit_now = chk_q && valid_q[chk_idx_q] && (tag_rdata == sector_q);

  // Clock hand step, wrapping at LINES
  assign hand_nxt = (hand_q == IW'(LINES - 1)) ? '0 : hand_q + 1'b1;

  // Lines awaiting writeback, and whether any lies above the current one
  assign vd = valid_q & dirty_q;
  always_comb begin
    for (int j = 0; j < LINES; j++) begin
      above[j] = (CW'(j) > idx_q);
    end
  end
  assign more_dirty = |(vd & above);

  // Tag read address: scan position, or the chosen victim
  always_comb begin
    tag_rd_addr = idx_line;
    if (state_q == cbcc_pkg::S_VREAD || state_q == cbcc_pkg::S_FILL) begin
      tag_rd_addr = victim_q;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbcc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (operation_i == cbcc_pkg::OP_READ || operation_i == cbcc_pkg::OP_WRITE) begin
            state_d = cbcc_pkg::S_SEARCH;
          end else if (operation_i == cbcc_pkg::OP_FLUSH) begin
            state_d = (|vd) ? cbcc_pkg::S_FSCAN : cbcc_pkg::S_FEMPTY;
          end
        end
      end
      cbcc_pkg::S_SEARCH: begin
        if (hit_now) begin
          state_d = cbcc_pkg::S_HIT;
        end else if (scan_end) begin
          state_d = free_found_q ? cbcc_pkg::S_VREAD : cbcc_pkg::S_SWEEP;
        end
      end
      cbcc_pkg::S_SWEEP: begin
        if (!used_q[hand_nxt]) begin
          state_d = cbcc_pkg::S_VREAD;
        end
      end
      cbcc_pkg::S_VREAD: state_d = cbcc_pkg::S_FILL;
      cbcc_pkg::S_FILL,
      cbcc_pkg::S_HIT,
      cbcc_pkg::S_FEMPTY: begin
        if (out_free) begin
          state_d = cbcc_pkg::S_IDLE;
        end
      end
      cbcc_pkg::S_FSCAN: begin
        if (vd[idx_line]) begin
          state_d = cbcc_pkg::S_FEMIT;
        end
      end
      cbcc_pkg::S_FEMIT: begin
        if (out_free) begin
          state_d = more_dirty ? cbcc_pkg::S_FSCAN : cbcc_pkg::S_IDLE;
        end
      end
      default: state_d = cbcc_pkg::S_IDLE;
    endcase
  end

  // Datapath and result register
  always_comb begin
    op_d         = op_q;
    sector_d     = sector_q;
    idx_d        = idx_q;
    chk_d        = 1'b0;
    chk_idx_d    = chk_idx_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    victim_d     = victim_q;
    hand_d       = hand_q;
    valid_d      = valid_q;
    dirty_d      = dirty_q;
    used_d       = used_q;
    tag_we       = 1'b0;
    emit         = 1'b0;
    line_d       = line_q;
    hit_d        = hit_q;
    fill_d       = fill_q;
    wb_d         = wb_q;
    wbsec_d      = wbsec_q;
    last_d       = last_q;

    unique case (state_q)
      cbcc_pkg::S_IDLE: begin
        if (in_acc) begin
          op_d         = operation_i;
          sector_d     = sector_i;
          idx_d        = '0;
          free_found_d = 1'b0;
        end
      end
      cbcc_pkg::S_SEARCH: begin
        if (!scan_end) begin
          // Issue the read for this line; note the lowest free line on the way
          chk_d     = 1'b1;
          chk_idx_d = idx_line;
          idx_d     = idx_q + 1'b1;
          if (!free_found_q && !valid_q[idx_line]) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_line;
          end
        end
        if (hit_now) begin
          victim_d = chk_idx_q;
        end else if (scan_end && free_found_q) begin
          victim_d = free_idx_q;
        end
      end
      cbcc_pkg::S_SWEEP: begin
        // Advance the hand; give used lines a second chance
        hand_d = hand_nxt;
        if (!used_q[hand_nxt]) begin
          victim_d = hand_nxt;
        end else begin
          used_d[hand_nxt] = 1'b0;
        end
      end
      cbcc_pkg::S_VREAD: ;
      cbcc_pkg::S_FILL: begin
        if (out_free) begin
          emit             = 1'b1;
          tag_we           = 1'b1;
          line_d           = LW'(victim_q);
          hit_d            = 1'b0;
          fill_d           = 1'b1;
          wb_d             = vd[victim_q];
          wbsec_d          = vd[victim_q] ? tag_rdata : '0;
          last_d           = 1'b1;
          valid_d[victim_q] = 1'b1;
          used_d[victim_q]  = 1'b1;
          dirty_d[victim_q] = (op_q == cbcc_pkg::OP_WRITE);
        end
      end
      cbcc_pkg::S_HIT: begin
        if (out_free) begin
          emit             = 1'b1;
          line_d           = LW'(victim_q);
          hit_d            = 1'b1;
          fill_d           = 1'b0;
          wb_d             = 1'b0;
          wbsec_d          = '0;
          last_d           = 1'b1;
          used_d[victim_q] = 1'b1;
          if (op_q == cbcc_pkg::OP_WRITE) begin
            dirty_d[victim_q] = 1'b1;
          end
        end
      end
      cbcc_pkg::S_FSCAN: begin
        if (!vd[idx_line]) begin
          idx_d = idx_q + 1'b1;
        end
      end
      cbcc_pkg::S_FEMIT: begin
        if (out_free) begin
          emit              = 1'b1;
          line_d            = LW'(idx_line);
          hit_d             = 1'b0;
          fill_d            = 1'b0;
          wb_d              = 1'b1;
          wbsec_d           = tag_rdata;
          last_d            = !more_dirty;
          dirty_d[idx_line] = 1'b0;
          idx_d             = idx_q + 1'b1;
        end
      end
      cbcc_pkg::S_FEMPTY: begin
        if (out_free) begin
          emit    = 1'b1;
          line_d  = '0;
          hit_d   = 1'b0;
          fill_d  = 1'b0;
          wb_d    = 1'b0;
          wbsec_d = '0;
          last_d  = 1'b1;
        end
      end
      default: ;
    endcase

    // Hold the result until it is taken; load a new one only into a free slot
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cbcc_pkg::S_IDLE;
      chk_q        <= 1'b0;
      free_found_q <= 1'b0;
      idx_q        <= '0;
      hand_q       <= '0;
      valid_q      <= '0;
      dirty_q      <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      chk_q        <= chk_d;
      free_found_q <= free_found_d;
      idx_q        <= idx_d;
      hand_q       <= hand_d;
      valid_q      <= valid_d;
      dirty_q      <= dirty_d;
      used_q       <= used_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    sector_q  <= sector_d;
    chk_idx_q <= chk_idx_d;
    free_idx_q <= free_idx_d;
    victim_q  <= victim_d;
    line_q    <= line_d;
    hit_q     <= hit_d;
    fill_q    <= fill_d;
    wb_q      <= wb_d;
    wbsec_q   <= wbsec_d;
    last_q    <= last_d;
  end

  assign out_valid_o        = out_valid_q;
  assign line_o             = line_q;
  assign hit_o              = hit_q;
  assign fill_o             = fill_q;
  assign writeback_o        = wb_q;
  assign writeback_sector_o = wbsec_q;
  assign last_o             = last_q;

  // The hand never leaves the line range
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_q <= IW'(LINES - 1))
    else $error("clock hand beyond last line");

  // A victim is either a free line or one the sweep found unused
  a_victim_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbcc_pkg::S_FILL) |-> !(valid_q[victim_q] && used_q[victim_q]))
    else $error("victim line still marked used");

  // Flush only writes back lines that are valid and dirty
  a_flush_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbcc_pkg::S_FEMIT) |-> vd[idx_line])
    else $error("flush writeback of a clean line");

  // The final beat of an item returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && last_d) |=> (state_q == cbcc_pkg::S_IDLE))
    else $error("sequencer busy after final beat");

endmodule

@@ hdl/cbcc_tag_ram.sv @@
// Single write port, single registered read port tag store.
// Depends on nothing; sized by its parameters.
module cbcc_tag_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sim/cbcc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the sector cache tag and clock-replacement controller: watches both
// channels, predicts every result beat and compares field by field. Depends on cbcc_pkg.
module cbcc_checker #(
  parameter int LINES = cbcc_pkg::LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [cbcc_pkg::OP_W-1:0]     operation_i,
  input  logic [cbcc_pkg::SECTOR_W-1:0] sector_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [cbcc_pkg::LINE_W-1:0]   line_i,
  input  logic                          hit_i,
  input  logic                          fill_i,
  input  logic                          writeback_i,
  input  logic [cbcc_pkg::SECTOR_W-1:0] writeback_sector_i,
  input  logic                          last_i,
  output int                            pending_o,
  output int                            errors_o
);

  typedef struct packed {
    logic [cbcc_pkg::LINE_W-1:0]   line;
    logic                          hit;
    logic                          fill;
    logic                          writeback;
    logic [cbcc_pkg::SECTOR_W-1:0] wb_sector;
    logic                          last;
  } cache_reply_t;

  cache_reply_t                  pending_replies[$];
  logic [cbcc_pkg::SECTOR_W-1:0] line_sector [LINES];
  logic [LINES-1:0]              line_valid;
  logic [LINES-1:0]              line_dirty;
  logic [LINES-1:0]              line_used;
  logic [cbcc_pkg::LINE_W-1:0]   sweep_pos;
  int                            mismatch_count = 0;

  function automatic logic [cbcc_pkg::LINE_W-1:0] advance_hand(
      input logic [cbcc_pkg::LINE_W-1:0] pos);
    return cbcc_pkg::LINE_W'((int'(pos) + 1) % LINES);
  endfunction

  // Search the tags; on a miss take the lowest free line, else sweep the clock.
  task automatic lookup_sector(input logic [cbcc_pkg::OP_W-1:0] op,
                               input logic [cbcc_pkg::SECTOR_W-1:0] sec);
    int           slot;
    logic         dirty_victim;
    cache_reply_t reply;
    slot = -1;
    for (int i = 0; i < LINES; i++) begin
      if (slot < 0 && line_valid[i] && line_sector[i] == sec) slot = i;
    end
    if (slot >= 0) begin
      line_used[slot] = 1'b1;
      if (op == cbcc_pkg::OP_WRITE) line_dirty[slot] = 1'b1;
      reply = '{line: cbcc_pkg::LINE_W'(slot), hit: 1'b1, fill: 1'b0, writeback: 1'b0,
                wb_sector: '0, last: 1'b1};
    end else begin
      for (int i = 0; i < LINES; i++) begin
        if (slot < 0 && !line_valid[i]) slot = i;
      end
      if (slot < 0) begin
        sweep_pos = advance_hand(sweep_pos);
        while (line_used[sweep_pos]) begin
          line_used[sweep_pos] = 1'b0;
          sweep_pos = advance_hand(sweep_pos);
        end
        slot = sweep_pos;
      end
      dirty_victim = line_valid[slot] && line_dirty[slot];
      reply = '{line: cbcc_pkg::LINE_W'(slot), hit: 1'b0, fill: 1'b1,
                writeback: dirty_victim,
                wb_sector: dirty_victim ? line_sector[slot] : '0, last: 1'b1};
      line_sector[slot] = sec;
      line_valid[slot]  = 1'b1;
      line_used[slot]   = 1'b1;
      line_dirty[slot]  = (op == cbcc_pkg::OP_WRITE);
    end
    pending_replies.push_back(reply);
  endtask

  // One writeback per valid dirty line in ascending order, or a single empty beat.
  task automatic flush_dirty();
    int final_line;
    final_line = -1;
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i] && line_dirty[i]) final_line = i;
    end
    if (final_line < 0) begin
      pending_replies.push_back('{line: '0, hit: 1'b0, fill: 1'b0, writeback: 1'b0,
                                  wb_sector: '0, last: 1'b1});
    end
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i] && line_dirty[i]) begin
        pending_replies.push_back('{line: cbcc_pkg::LINE_W'(i), hit: 1'b0, fill: 1'b0,
                                    writeback: 1'b1, wb_sector: line_sector[i],
                                    last: (i == final_line)});
        line_dirty[i] = 1'b0;
      end
    end
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cache_reply_t want;
    if (!rst_ni) begin
      line_valid = '0;
      line_dirty = '0;
      line_used  = '0;
      sweep_pos  = '0;
      pending_replies.delete();
    end else begin
      // Retire the returning beat before predicting a new one.
      if (out_valid_i && !out_stall_i) begin
        if (pending_replies.size() == 0) begin
          $error("result beat with nothing expected: line %0d", line_i);
          mismatch_count++;
        end else begin
          want = pending_replies.pop_front();
          check_field("line", 32'(want.line), 32'(line_i));
          check_field("hit", 32'(want.hit), 32'(hit_i));
          check_field("fill", 32'(want.fill), 32'(fill_i));
          check_field("writeback", 32'(want.writeback), 32'(writeback_i));
          check_field("writeback_sector", want.wb_sector, writeback_sector_i);
          check_field("last", 32'(want.last), 32'(last_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (operation_i) inside
          cbcc_pkg::OP_READ, cbcc_pkg::OP_WRITE: lookup_sector(operation_i, sector_i);
          cbcc_pkg::OP_FLUSH:                    flush_dirty();
          default:                               ;
        endcase
      end
    end
    pending_o = pending_replies.size();
    errors_o  = mismatch_count;
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Top of the cache controller testbench: clock, reset, access stimulus and result sink,
// watchdog and verdict. Depends on cbcc_pkg, cbcc_checker and the controller core.
module tb;

  // Operation code that the controller must drop without touching its state.
  localparam logic [cbcc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int ACCESS_BEATS   = 350;
  localparam int POOL_DEPTH     = 80;
  localparam int HOLD_AT_BEAT   = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 200;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [cbcc_pkg::OP_W-1:0]     operation = cbcc_pkg::OP_READ;
  logic [cbcc_pkg::SECTOR_W-1:0] sector    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [cbcc_pkg::LINE_W-1:0]   line;
  logic                          hit;
  logic                          fill;
  logic                          writeback;
  logic [cbcc_pkg::SECTOR_W-1:0] writeback_sector;
  logic                          last;

  int                            replies_due;
  int                            check_errors;
  int                            idle_cycles = 0;
  bit                            send_fast   = 1'b0;
  logic [cbcc_pkg::SECTOR_W-1:0] sector_pool [POOL_DEPTH];

  // 4 ns period: two ns high, two ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  clock_buffer_cache_controller_core uut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .sector_i           (sector),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .line_o             (line),
    .hit_o              (hit),
    .fill_o             (fill),
    .writeback_o        (writeback),
    .writeback_sector_o (writeback_sector),
    .last_o             (last)
  );

  cbcc_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .operation_i        (operation),
    .sector_i           (sector),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .line_i             (line),
    .hit_i              (hit),
    .fill_i             (fill),
    .writeback_i        (writeback),
    .writeback_sector_i (writeback_sector),
    .last_i             (last),
    .pending_o          (replies_due),
    .errors_o           (check_errors)
  );

  // Offer one request beat after a random gap and hold it until accepted.
  // Raise valid again in the step of acceptance when no gap is drawn, so the
  // channel can run back to back.
  task automatic send_request(input logic [cbcc_pkg::OP_W-1:0] op,
                              input logic [cbcc_pkg::SECTOR_W-1:0] sec);
    int gap;
    gap = send_fast ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    sector    <= sec;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Drop valid and hold off until every predicted result beat has come back.
  // Sample the count on the falling edge, clear of the checker's update.
  task automatic drain_replies();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_due != 0);
    @(posedge clk);
  endtask

  // Random requests: mostly reads and writes over a pool a little larger than
  // the cache, so it fills, hits often and keeps the clock sweep busy.
  // Stir in flushes, stray sectors and the unused opcode as noise.
  task automatic random_requests(input int count);
    int sent;
    int pick;
    logic [cbcc_pkg::SECTOR_W-1:0] sec;
    sent = 0;
    while (sent < count) begin
      if (sent % 16 == 0) send_fast = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      sec  = ($urandom_range(0, 9) == 0) ? $urandom()
                                         : sector_pool[$urandom_range(0, POOL_DEPTH - 1)];
      if (pick < 2) begin
        send_request(OP_UNUSED, $urandom());
      end else begin
        if (pick < 6)       send_request(cbcc_pkg::OP_FLUSH, $urandom());
        else if (pick < 52) send_request(cbcc_pkg::OP_READ, sec);
        else                send_request(cbcc_pkg::OP_WRITE, sec);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int directed;
    sector_pool[0] = '0;
    sector_pool[1] = '1;
    for (int i = 2; i < POOL_DEPTH; i++) sector_pool[i] = $urandom();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening: empty flush, miss into a free line, hits on read and
    // write, the unused opcode, flush with dirty lines, then an empty flush again.
    send_request(cbcc_pkg::OP_FLUSH, '0);
    send_request(cbcc_pkg::OP_READ, 32'h0000_0000);
    send_request(cbcc_pkg::OP_WRITE, 32'hFFFF_FFFF);
    send_request(cbcc_pkg::OP_READ, 32'h0000_0000);
    send_request(cbcc_pkg::OP_WRITE, 32'h0000_0000);
    send_request(cbcc_pkg::OP_READ, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hA5A5_A5A5);
    send_request(OP_UNUSED, 32'h0000_0000);
    send_request(cbcc_pkg::OP_FLUSH, 32'h5A5A_5A5A);
    send_request(cbcc_pkg::OP_FLUSH, 32'hFFFF_FFFF);
    send_request(cbcc_pkg::OP_WRITE, 32'h8000_0001);
    send_request(cbcc_pkg::OP_READ, 32'h7FFF_FFFE);
    send_request(cbcc_pkg::OP_WRITE, 32'h7FFF_FFFE);
    send_request(cbcc_pkg::OP_FLUSH, '0);
    directed = 12;

    // Pause the sender until the directed results are all home.
    drain_replies();

    random_requests((ACCESS_BEATS - directed) / 2);
    drain_replies();
    random_requests(ACCESS_BEATS - directed - (ACCESS_BEATS - directed) / 2);

    // Let the pipeline settle so a stray late beat still gets caught.
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (check_errors == 0) begin
      $display("clock_buffer_cache_controller_core verification clean");
    end else begin
      $display("clock_buffer_cache_controller_core verification failed");
    end
    $finish;
  end

  // Result sink: stall for a random number of cycles before each beat, with
  // stretches of no stall at all, and one long hold-off that backs the
  // controller up so it has to stall its own input.
  initial begin : result_sink
    int gap;
    int beats;
    bit fast;
    beats = 0;
    fast  = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (beats % 16 == 0) fast = ($urandom_range(0, 2) == 0);
      if (beats == HOLD_AT_BEAT) gap = HOLD_CYCLES;
      else                       gap = fast ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      beats++;
    end
  end

  // Watchdog: count cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("clock_buffer_cache_controller_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
